>>> src/dpcm_pkg.sv
package dpcm_pkg;

  // Parameter store geometry: bytes are kept as two byte lanes of one word row.
  localparam int STORE_BYTES = 4096;
  localparam int BYTE_W      = $clog2(STORE_BYTES);
  localparam int STORE_ROWS  = STORE_BYTES / 2;
  localparam int ROW_W       = $clog2(STORE_ROWS);

  typedef enum logic [3:0] {
    OP_CMD       = 4'd0,
    OP_CMD2      = 4'd1,
    OP_PARAM     = 4'd2,
    OP_PARAM2    = 4'd3,
    OP_GET_STAT  = 4'd4,
    OP_GET_STAT2 = 4'd5,
    OP_CLR_STAT  = 4'd6,
    OP_CLR_STAT2 = 4'd7,
    OP_PACK      = 4'd8,
    OP_PACK2     = 4'd9,
    OP_DMA_WR    = 4'd10,
    OP_DMA_RD    = 4'd11,
    OP_RAM_RD    = 4'd12,
    OP_RAM_WR    = 4'd13,
    OP_LOGIC_RD  = 4'd14,
    OP_LOGIC_WR  = 4'd15
  } op_t;

  // Host command values below this select a port instead of issuing a command.
  localparam logic [15:0] PORT_SEL_LIMIT = 16'h1000;

  // Fixed byte addresses in the parameter store.
  localparam logic [BYTE_W-1:0] PARAM_ADDR   = 12'hCC6;
  localparam logic [BYTE_W-1:0] PARAM2_ADDR  = 12'hB86;
  localparam logic [BYTE_W-1:0] DMA_SA_BASE  = 12'hCD8;
  localparam logic [BYTE_W-1:0] DMA_SL_BASE  = 12'hCE8;
  localparam logic [BYTE_W-1:0] DMA_RA_BASE  = 12'hCF0;
  localparam logic [BYTE_W-1:0] DMA_RL_BASE  = 12'hCF8;
  localparam logic [BYTE_W-1:0] PORT_HI_OFFS = 12'h0C0;

  // Local window offsets that are decoded on the full 16-bit address.
  localparam logic [15:0] LW_CMD2_LO = 16'hB82;
  localparam logic [15:0] LW_CMD2_HI = 16'hB83;
  localparam logic [15:0] LW_STAT2_LO = 16'hB84;
  localparam logic [15:0] LW_STAT2_HI = 16'hB85;
  localparam logic [15:0] LW_CMD_LO  = 16'hCC2;
  localparam logic [15:0] LW_CMD_HI  = 16'hCC3;
  localparam logic [15:0] LW_STAT_LO = 16'hCC4;
  localparam logic [15:0] LW_STAT_HI = 16'hCC5;

  // Logic register offsets and the constant values they return.
  localparam logic [15:0] LR_REARM = 16'h0010;
  localparam logic [15:0] LR_ACK   = 16'h0011;
  localparam logic [15:0] LR_ACK2  = 16'h0012;
  localparam logic [15:0] LR_ID    = 16'h0019;
  localparam logic [15:0] LR_FLAGS = 16'h001D;
  localparam logic [15:0] LR_REV   = 16'h0080;
  localparam logic [7:0]  LR_ID_VAL    = 8'h7F;
  localparam logic [7:0]  LR_REV_VAL   = 8'h05;
  localparam logic [7:0]  LR_OTHER_VAL = 8'hFF;

  // Status word bits.
  localparam logic [15:0] STAT_VALID_BIT = 16'h0040;
  localparam logic [15:0] STAT_READ_BIT  = 16'h0008;

  // Request flag bits seen by the local processor.
  localparam logic [7:0] RF_CMD    = 8'h01;
  localparam logic [7:0] RF_PACK   = 8'h02;
  localparam logic [7:0] RF_CMD2   = 8'h04;
  localparam logic [7:0] RF_PACK2  = 8'h08;
  localparam logic [7:0] RF_STAT   = 8'h10;
  localparam logic [7:0] RF_STAT2  = 8'h20;
  localparam logic [7:0] RF_PARAM  = 8'h40;
  localparam logic [7:0] RF_PARAM2 = 8'h80;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [15:0]      data;
    logic [1:0]       be;
  } store_wr_t;

  typedef struct packed {
    logic [15:0] rd_data;
    logic        irq;
    logic        busy;
  } result_t;

  function automatic logic [BYTE_W-1:0] dma_byte_addr(input logic [1:0] sel,
                                                      input logic [2:0] port);
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] offs;
    begin
      case (sel)
        2'd0:    base = DMA_SA_BASE;
        2'd1:    base = DMA_SL_BASE;
        2'd2:    base = DMA_RA_BASE;
        default: base = DMA_RL_BASE;
      endcase
      offs = (port[2] ? PORT_HI_OFFS : '0)
           + BYTE_W'({port[0], 2'b00})
           + BYTE_W'({port[1], 1'b0});
      return base + offs;
    end
  endfunction

  // Word row touched by an access; all word accesses sit on even byte addresses.
  function automatic logic [ROW_W-1:0] access_row(input logic [3:0] op,
                                                  input logic [15:0] addr,
                                                  input logic [2:0] port);
    logic [BYTE_W-1:0] ba;
    begin
      case (op_t'(op)) inside
        OP_PARAM:             ba = PARAM_ADDR;
        OP_PARAM2:            ba = PARAM2_ADDR;
        OP_DMA_WR, OP_DMA_RD: ba = dma_byte_addr(addr[1:0], port);
        default:              ba = addr[BYTE_W-1:0];
      endcase
      return ba[BYTE_W-1:1];
    end
  endfunction

endpackage

>>> src/dual_port_command_mailbox_top.sv
// Host-to-local-processor command mailbox. Each input beat is one bus access
// (host command, parameter, status or DMA parameter access, or a local RAM or
// logic register access) and produces exactly one result beat carrying the read
// data, the local interrupt-two pulse and the busy flag after the access. The
// block takes one beat per clock cycle when no stall or clearing holds it off.
// An accepted beat is latched into the access register as the 4 KB parameter
// store, whose read port is registered, is read; when the access completes,
// the register and store update is applied and the output register loaded.
// An access accepted in the same cycle as a write to its store word sees the
// new bytes through a forwarding register. After reset the store is zeroed
// by a pass over all 2048 rows, one 16-bit row per cycle, during which
// in_tready stays low. The output register decouples the two sides, so a new
// beat is still accepted while a finished result waits for out_tready.
module dual_port_command_mailbox_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // opcode[3:0], address[19:4], data_word[35:20], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // read_data[15:0], irq_pulse[16], busy_flag[17], zero
);
  import dpcm_pkg::*;

  logic             s1_valid_r;
  logic [3:0]       s1_op_r;
  logic [15:0]      s1_addr_r;
  logic [15:0]      s1_dw_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             out_valid_r;
  result_t          out_res_r;

  logic             s1_fire;
  logic             accept;
  logic             clearing;
  logic [2:0]       port_next;
  logic [ROW_W-1:0] rd_row;
  logic [15:0]      mem_word;
  store_wr_t        wr;
  result_t          res;

  // The access stage completes whenever the output register is free or drains.
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clearing && (!s1_valid_r || s1_fire);
  assign accept    = in_tvalid && in_tready;

  // The store row uses the port select as it stands after the access now
  // completing, so a port change is seen by the very next beat.
  assign rd_row = access_row(in_tdata[3:0], in_tdata[19:4], port_next);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= in_tdata[3:0];
      s1_addr_r <= in_tdata[19:4];
      s1_dw_r   <= in_tdata[35:20];
      s1_row_r  <= rd_row;
    end
  end

  dpcm_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_row   (rd_row),
    .wr       (wr),
    .rd_word  (mem_word),
    .clearing (clearing)
  );

  dpcm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_fire),
    .op        (s1_op_r),
    .addr      (s1_addr_r),
    .dw        (s1_dw_r),
    .row       (s1_row_r),
    .mem_word  (mem_word),
    .port_next (port_next),
    .wr        (wr),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.busy, out_res_r.irq, out_res_r.rd_data};

endmodule

>>> src/dpcm_store.sv
module dpcm_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [dpcm_pkg::ROW_W-1:0] rd_row,
  input  dpcm_pkg::store_wr_t        wr,
  output logic [15:0]                rd_word,
  output logic                       clearing
);
  import dpcm_pkg::*;

  logic [7:0]       mem_lo_r [STORE_ROWS];
  logic [7:0]       mem_hi_r [STORE_ROWS];
  logic [7:0]       q_lo_r;
  logic [7:0]       q_hi_r;
  logic             clearing_r;
  logic [ROW_W-1:0] clr_cnt_r;
  logic [1:0]       fwd_be_r;
  logic [15:0]      fwd_data_r;

  logic             we_lo;
  logic             we_hi;
  logic [ROW_W-1:0] waddr;
  logic [15:0]      wdata;

  // After reset every row is zeroed, one row per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == ROW_W'(STORE_ROWS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_comb begin
    we_lo = clearing_r | (wr.en & wr.be[0]);
    we_hi = clearing_r | (wr.en & wr.be[1]);
    waddr = clearing_r ? clr_cnt_r : wr.row;
    wdata = clearing_r ? 16'h0000 : wr.data;
  end

  always_ff @(posedge clk) begin
    if (we_lo) begin
      mem_lo_r[waddr] <= wdata[7:0];
    end
    if (we_hi) begin
      mem_hi_r[waddr] <= wdata[15:8];
    end
    if (rd_en) begin
      q_lo_r <= mem_lo_r[rd_row];
      q_hi_r <= mem_hi_r[rd_row];
    end
  end

  // A read issued in the same cycle as a write to its row sees the old data,
  // so the written lanes are kept and merged over the read word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_be_r <= 2'b00;
    end else if (rd_en) begin
      fwd_be_r <= (wr.en && (wr.row == rd_row)) ? wr.be : 2'b00;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr.data;
    end
  end

  assign rd_word  = {fwd_be_r[1] ? fwd_data_r[15:8] : q_hi_r,
                     fwd_be_r[0] ? fwd_data_r[7:0]  : q_lo_r};
  assign clearing = clearing_r;

endmodule

>>> src/dpcm_core.sv
module dpcm_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic [3:0]                 op,
  input  logic [15:0]                addr,
  input  logic [15:0]                dw,
  input  logic [dpcm_pkg::ROW_W-1:0] row,
  input  logic [15:0]                mem_word,
  output logic [2:0]                 port_next,
  output dpcm_pkg::store_wr_t        wr,
  output dpcm_pkg::result_t          res
);
  import dpcm_pkg::*;

  logic [15:0] cmd_r, cmd_nxt;
  logic [15:0] cmd2_r, cmd2_nxt;
  logic [7:0]  rf_r, rf_nxt;
  logic [2:0]  port_r, port_nxt;
  logic [15:0] hs_r, hs_nxt;
  logic [15:0] hs2_r, hs2_nxt;
  logic [15:0] sh_r, sh_nxt;
  logic [15:0] sh2_r, sh2_nxt;
  logic        valid_r, valid_nxt;
  logic        req_r, req_nxt;
  logic        valid2_r, valid2_nxt;
  logic        req2_r, req2_nxt;
  logic        busy_r, busy_nxt;
  logic [15:0] rd;
  logic        irq;
  logic [7:0]  lo;
  logic [7:0]  lane;
  logic        dma_ok;

  always_comb begin
    cmd_nxt    = cmd_r;
    cmd2_nxt   = cmd2_r;
    rf_nxt     = rf_r;
    port_nxt   = port_r;
    hs_nxt     = hs_r;
    hs2_nxt    = hs2_r;
    sh_nxt     = sh_r;
    sh2_nxt    = sh2_r;
    valid_nxt  = valid_r;
    req_nxt    = req_r;
    valid2_nxt = valid2_r;
    req2_nxt   = req2_r;
    busy_nxt   = busy_r;
    rd         = 16'h0000;
    irq        = 1'b0;
    lo         = dw[7:0];
    lane       = addr[0] ? mem_word[15:8] : mem_word[7:0];
    dma_ok     = (addr[15:2] == 14'd0);
    wr.en      = 1'b0;
    wr.row     = row;
    wr.data    = dw;
    wr.be      = 2'b11;

    if (fire) begin
      unique case (op_t'(op))
        OP_CMD: begin
          if (dw < PORT_SEL_LIMIT) begin
            port_nxt = dw[2:0];
          end else begin
            cmd_nxt   = dw;
            rf_nxt    = rf_r | RF_CMD;
            busy_nxt  = 1'b1;
            hs_nxt    = 16'h0000;
            valid_nxt = 1'b0;
            irq       = 1'b1;
          end
        end
        OP_CMD2: begin
          cmd2_nxt = dw;
          rf_nxt   = rf_r | RF_CMD2;
          busy_nxt = 1'b1;
          irq      = 1'b1;
        end
        OP_PARAM: begin
          wr.en  = 1'b1;
          rf_nxt = rf_r | RF_PARAM;
          irq    = 1'b1;
        end
        OP_PARAM2: begin
          wr.en  = 1'b1;
          rf_nxt = rf_r | RF_PARAM2;
          irq    = 1'b1;
        end
        OP_GET_STAT:  rd = hs_r | STAT_READ_BIT;
        OP_GET_STAT2: rd = hs2_r | STAT_READ_BIT;
        OP_CLR_STAT: begin
          // A pending acknowledge promotes the shadow status at once.
          if (req_r) begin
            hs_nxt    = sh_r | STAT_VALID_BIT;
            valid_nxt = 1'b1;
            req_nxt   = 1'b0;
            rf_nxt    = rf_r | RF_STAT;
            irq       = 1'b1;
          end else begin
            hs_nxt    = 16'h0000;
            valid_nxt = 1'b0;
          end
        end
        OP_CLR_STAT2: begin
          if (req2_r) begin
            hs2_nxt    = sh2_r | STAT_VALID_BIT;
            valid2_nxt = 1'b1;
            req2_nxt   = 1'b0;
            rf_nxt     = rf_r | RF_STAT2;
            irq        = 1'b1;
          end else begin
            hs2_nxt    = 16'h0000;
            valid2_nxt = 1'b0;
          end
        end
        OP_PACK: begin
          rf_nxt = rf_r | RF_PACK;
          irq    = 1'b1;
        end
        OP_PACK2: begin
          rf_nxt = rf_r | RF_PACK2;
          irq    = 1'b1;
        end
        OP_DMA_WR: wr.en = dma_ok;
        OP_DMA_RD: rd = dma_ok ? mem_word : 16'h0000;
        OP_RAM_RD: begin
          if (addr == LW_CMD2_LO) begin
            rd = {8'h00, cmd2_r[7:0]};
          end else if (addr == LW_CMD2_HI) begin
            rd = {8'h00, cmd2_r[15:8]};
          end else if (addr == LW_CMD_LO) begin
            rd = {8'h00, cmd_r[7:0]};
          end else if (addr == LW_CMD_HI) begin
            rd = {8'h00, cmd_r[15:8]};
          end else begin
            rd = {8'h00, lane};
          end
        end
        OP_RAM_WR: begin
          wr.en   = 1'b1;
          wr.data = {lo, lo};
          wr.be   = addr[0] ? 2'b10 : 2'b01;
          if (addr == LW_STAT2_LO) begin
            sh2_nxt = {sh2_r[15:8], lo};
          end else if (addr == LW_STAT2_HI) begin
            sh2_nxt = {lo, sh2_r[7:0]};
            hs2_nxt = hs2_r | STAT_VALID_BIT;
          end else if (addr == LW_STAT_LO) begin
            sh_nxt = {sh_r[15:8], lo};
          end else if (addr == LW_STAT_HI) begin
            sh_nxt = {lo, sh_r[7:0]};
          end
        end
        OP_LOGIC_RD: begin
          if (addr == LR_ID) begin
            rd = {8'h00, LR_ID_VAL};
          end else if (addr == LR_FLAGS) begin
            rd     = {8'h00, rf_r};
            rf_nxt = 8'h00;
          end else if (addr == LR_REV) begin
            rd = {8'h00, LR_REV_VAL};
          end else begin
            rd = {8'h00, LR_OTHER_VAL};
          end
        end
        OP_LOGIC_WR: begin
          if (addr == LR_REARM) begin
            busy_nxt = (rf_r != 8'h00);
            irq      = (rf_r != 8'h00);
          end else if (addr == LR_ACK) begin
            // Acknowledge with no valid status promotes and clears the request.
            if (!valid_r) begin
              hs_nxt    = sh_r | STAT_VALID_BIT;
              valid_nxt = 1'b1;
              req_nxt   = 1'b0;
              rf_nxt    = rf_r | RF_STAT;
              irq       = 1'b1;
            end else begin
              req_nxt = 1'b1;
            end
          end else if (addr == LR_ACK2) begin
            if (!valid2_r) begin
              hs2_nxt    = sh2_r | STAT_VALID_BIT;
              valid2_nxt = 1'b1;
              req2_nxt   = 1'b0;
              rf_nxt     = rf_r | RF_STAT2;
              irq        = 1'b1;
            end else begin
              req2_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    res.rd_data = rd;
    res.irq     = irq;
    res.busy    = busy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r    <= '0;
      cmd2_r   <= '0;
      rf_r     <= '0;
      port_r   <= '0;
      hs_r     <= '0;
      hs2_r    <= '0;
      sh_r     <= '0;
      sh2_r    <= '0;
      valid_r  <= 1'b0;
      req_r    <= 1'b0;
      valid2_r <= 1'b0;
      req2_r   <= 1'b0;
      busy_r   <= 1'b1;
    end else begin
      cmd_r    <= cmd_nxt;
      cmd2_r   <= cmd2_nxt;
      rf_r     <= rf_nxt;
      port_r   <= port_nxt;
      hs_r     <= hs_nxt;
      hs2_r    <= hs2_nxt;
      sh_r     <= sh_nxt;
      sh2_r    <= sh2_nxt;
      valid_r  <= valid_nxt;
      req_r    <= req_nxt;
      valid2_r <= valid2_nxt;
      req2_r   <= req2_nxt;
      busy_r   <= busy_nxt;
    end
  end

  assign port_next = port_nxt;

endmodule

>>> src/dpcm_checker.sv
module dpcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // The store clearing pass holds off input right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  // A result appearing in an empty output register comes from a beat that was
  // taken earlier and then held in the access register.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result beat without a matching input beat");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:18] == 6'd0)
    else $error("result padding bits not zero");

endmodule

bind dual_port_command_mailbox_top dpcm_checker u_dpcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/sv/dpcm_mailbox_checker.sv
module dpcm_mailbox_checker
  import dpcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // opcode[3:0], address[19:4], data_word[35:20], zero
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // read_data[15:0], irq_pulse[16], busy_flag[17], zero
  output int          fail_count,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]  op;
    logic [15:0] addr;
    logic [15:0] read_data;
    logic        irq_pulse;
    logic        busy_flag;
  } mbox_expect_t;

  // Mirror of the mailbox state.
  logic [7:0]  param_bytes [STORE_BYTES];
  logic [15:0] cmd_word, cmd_word2;
  logic [7:0]  req_flags;
  logic [2:0]  port_sel;
  logic [15:0] host_stat, host_stat2;
  logic [15:0] shadow_stat, shadow_stat2;
  logic        stat_valid, stat_req, stat2_valid, stat2_req;
  logic        busy_q;

  mbox_expect_t expected_beats [$];
  mbox_expect_t want;
  mbox_expect_t got;
  logic         beat_bad;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  task automatic clear_mailbox();
    for (int i = 0; i < STORE_BYTES; i++) param_bytes[i] = 8'h00;
    cmd_word     = '0;
    cmd_word2    = '0;
    req_flags    = '0;
    port_sel     = '0;
    host_stat    = '0;
    host_stat2   = '0;
    shadow_stat  = '0;
    shadow_stat2 = '0;
    stat_valid   = 1'b0;
    stat_req     = 1'b0;
    stat2_valid  = 1'b0;
    stat2_req    = 1'b0;
    busy_q       = 1'b1;
  endtask

  task automatic put_le_word(input logic [11:0] a, input logic [15:0] v);
    param_bytes[a]          = v[7:0];
    param_bytes[a + 12'd1]  = v[15:8];
  endtask

  // Byte address of one DMA parameter for the port that is currently selected.
  function automatic logic [11:0] dma_slot(input logic [1:0] sel);
    logic [11:0] base;
    case (sel)
      2'd0:    base = 12'hCD8;
      2'd1:    base = 12'hCE8;
      2'd2:    base = 12'hCF0;
      default: base = 12'hCF8;
    endcase
    return base + (port_sel[2] ? 12'h0C0 : 12'h000)
         + 12'({port_sel[0], 2'b00}) + 12'({port_sel[1], 1'b0});
  endfunction

  function automatic logic promote_main();
    logic fired;
    host_stat  = shadow_stat | STAT_VALID_BIT;
    stat_valid = 1'b1;
    fired      = stat_req;
    if (stat_req) req_flags |= RF_STAT;
    stat_req = 1'b0;
    return fired;
  endfunction

  function automatic logic promote_second();
    logic fired;
    host_stat2  = shadow_stat2 | STAT_VALID_BIT;
    stat2_valid = 1'b1;
    fired       = stat2_req;
    if (stat2_req) req_flags |= RF_STAT2;
    stat2_req = 1'b0;
    return fired;
  endfunction

  task automatic mailbox_access(input op_t op, input logic [15:0] addr,
                                input logic [15:0] dw, output mbox_expect_t res);
    logic [15:0] rd;
    logic        irq;
    logic [11:0] a;
    rd  = '0;
    irq = 1'b0;
    case (op)
      OP_CMD: begin
        if (dw < PORT_SEL_LIMIT) begin
          port_sel = dw[2:0];
        end else begin
          cmd_word   = dw;
          req_flags |= RF_CMD;
          busy_q     = 1'b1;
          host_stat  = '0;
          stat_valid = 1'b0;
          irq        = 1'b1;
        end
      end
      OP_CMD2: begin
        cmd_word2  = dw;
        req_flags |= RF_CMD2;
        busy_q     = 1'b1;
        irq        = 1'b1;
      end
      OP_PARAM: begin
        put_le_word(12'hCC6, dw);
        req_flags |= RF_PARAM;
        irq        = 1'b1;
      end
      OP_PARAM2: begin
        put_le_word(12'hB86, dw);
        req_flags |= RF_PARAM2;
        irq        = 1'b1;
      end
      OP_GET_STAT:  rd = host_stat | STAT_READ_BIT;
      OP_GET_STAT2: rd = host_stat2 | STAT_READ_BIT;
      OP_CLR_STAT: begin
        host_stat  = '0;
        stat_valid = 1'b0;
        if (stat_req) irq = promote_main();
      end
      OP_CLR_STAT2: begin
        host_stat2  = '0;
        stat2_valid = 1'b0;
        if (stat2_req) irq = promote_second();
      end
      OP_PACK: begin
        req_flags |= RF_PACK;
        irq        = 1'b1;
      end
      OP_PACK2: begin
        req_flags |= RF_PACK2;
        irq        = 1'b1;
      end
      OP_DMA_WR: begin
        if (addr <= 16'd3) put_le_word(dma_slot(addr[1:0]), dw);
      end
      OP_DMA_RD: begin
        if (addr <= 16'd3) begin
          a  = dma_slot(addr[1:0]);
          rd = {param_bytes[a + 12'd1], param_bytes[a]};
        end
      end
      OP_RAM_RD: begin
        rd = {8'h00, param_bytes[addr[11:0]]};
        if (addr == LW_CMD2_LO)      rd = {8'h00, cmd_word2[7:0]};
        else if (addr == LW_CMD2_HI) rd = {8'h00, cmd_word2[15:8]};
        else if (addr == LW_CMD_LO)  rd = {8'h00, cmd_word[7:0]};
        else if (addr == LW_CMD_HI)  rd = {8'h00, cmd_word[15:8]};
      end
      OP_RAM_WR: begin
        param_bytes[addr[11:0]] = dw[7:0];
        if (addr == LW_STAT2_LO) begin
          shadow_stat2[7:0] = dw[7:0];
        end else if (addr == LW_STAT2_HI) begin
          shadow_stat2[15:8] = dw[7:0];
          host_stat2 |= STAT_VALID_BIT;
        end else if (addr == LW_STAT_LO) begin
          shadow_stat[7:0] = dw[7:0];
        end else if (addr == LW_STAT_HI) begin
          shadow_stat[15:8] = dw[7:0];
        end
      end
      OP_LOGIC_RD: begin
        if (addr == LR_ID) begin
          rd = {8'h00, LR_ID_VAL};
        end else if (addr == LR_FLAGS) begin
          rd        = {8'h00, req_flags};
          req_flags = '0;
        end else if (addr == LR_REV) begin
          rd = {8'h00, LR_REV_VAL};
        end else begin
          rd = {8'h00, LR_OTHER_VAL};
        end
      end
      default: begin
        if (addr == LR_REARM) begin
          busy_q = (req_flags != 8'h00);
          irq    = (req_flags != 8'h00);
        end else if (addr == LR_ACK) begin
          stat_req = 1'b1;
          if (!stat_valid) irq = promote_main();
        end else if (addr == LR_ACK2) begin
          stat2_req = 1'b1;
          if (!stat2_valid) irq = promote_second();
        end
      end
    endcase
    res.op        = op;
    res.addr      = addr;
    res.read_data = rd;
    res.irq_pulse = irq;
    res.busy_flag = busy_q;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_mailbox();
      expected_beats.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        mailbox_access(op_t'(in_tdata[3:0]), in_tdata[19:4], in_tdata[35:20], want);
        expected_beats.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.read_data = out_tdata[15:0];
        got.irq_pulse = out_tdata[16];
        got.busy_flag = out_tdata[17];
        if (expected_beats.size() == 0) begin
          $display("%0t: result beat with nothing expected, got read_data %h irq %b busy %b",
                   $time, got.read_data, got.irq_pulse, got.busy_flag);
          fail_count++;
        end else begin
          want     = expected_beats.pop_front();
          beat_bad = 1'b0;
          checked++;
          if (got.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch (op %0d addr %h), expected %h, got %h",
                     $time, want.op, want.addr, want.read_data, got.read_data);
            beat_bad = 1'b1;
          end
          if (got.irq_pulse !== want.irq_pulse) begin
            $display("%0t: irq_pulse mismatch (op %0d addr %h), expected %b, got %b",
                     $time, want.op, want.addr, want.irq_pulse, got.irq_pulse);
            beat_bad = 1'b1;
          end
          if (got.busy_flag !== want.busy_flag) begin
            $display("%0t: busy_flag mismatch (op %0d addr %h), expected %b, got %b",
                     $time, want.op, want.addr, want.busy_flag, got.busy_flag);
            beat_bad = 1'b1;
          end
          if (beat_bad) fail_count++;
        end
      end
    end
    pending = expected_beats.size();
  end

endmodule

>>> tb/sv/tb_dual_port_command_mailbox_top.sv
module tb_dual_port_command_mailbox_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dpcm_pkg::*;

  // The cycle limit covers every access even with heavy output stalls, and
  // the store clearing pass after reset on top.
  localparam int ACCESS_TARGET = 1050;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int DRAIN_CYCLES  = 16;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // opcode[3:0], address[19:4], data_word[35:20], zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // read_data[15:0], irq_pulse[16], busy_flag[17], zero

  int fail_count;
  int pending;
  int checked;

  // Sender bookkeeping: beats handed over so far and what is left of the burst.
  int beats_sent = 0;
  int directed_beats = 0;
  int burst_left = 0;

  // Receiver bookkeeping.
  int rx_mode = 0;
  int rx_left = 0;
  int rx_tick = 0;

  dual_port_command_mailbox_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  dpcm_mailbox_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver switches between a few stall patterns every so often: always
  // ready, mostly ready, mostly stalled, and a fixed duty cycle. Each pattern
  // lasts long enough that stalls land on every phase of the pipeline.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 150);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ($urandom_range(0, 2) == 0);
      default: out_tready <= ((rx_tick % 7) < 4);
    endcase
  end

  // Hands one access to the block. Beats go out in bursts; between bursts the
  // valid line drops for a random gap, and some bursts follow with no gap at
  // all. Valid is raised only here and lowered only in the gap or after the
  // last beat, so it never gets two assignments in the same time step. The task
  // returns at the rising edge where the beat was taken.
  task automatic send_access(input op_t op, input logic [15:0] addr,
                             input logic [15:0] dw);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'h0, dw, addr, 4'(op)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  // A local window offset: the command and status bytes, the parameter words,
  // the DMA parameter area of both port halves, aliases of those with upper
  // address bits set, or anything at all.
  function automatic logic [15:0] pick_window_addr();
    logic [15:0] marks [12];
    logic [15:0] a;
    marks = '{16'hB82, 16'hB83, 16'hB84, 16'hB85, 16'hB86, 16'hB87,
              16'hCC2, 16'hCC3, 16'hCC4, 16'hCC5, 16'hCC6, 16'hCC7};
    case ($urandom_range(0, 9))
      0, 1, 2: a = marks[$urandom_range(0, 11)];
      3:       a = 16'hCD8 + 16'($urandom_range(0, 39));
      4:       a = 16'hD98 + 16'($urandom_range(0, 39));
      5:       a = marks[$urandom_range(0, 11)] | {4'($urandom_range(1, 15)), 12'h000};
      6:       a = 16'($urandom_range(0, 65535));
      default: a = 16'($urandom_range(0, 4095));
    endcase
    return a;
  endfunction

  function automatic logic [15:0] pick_logic_addr();
    logic [15:0] regs [6];
    regs = '{LR_REARM, LR_ACK, LR_ACK2, LR_ID, LR_FLAGS, LR_REV};
    if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, 65535));
    return regs[$urandom_range(0, 5)];
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // One full exchange on a status channel, as firmware and host would run it:
  // the host issues a command (and maybe a parameter), the local side fetches
  // the flags and the command bytes, posts a shadow status and acknowledges,
  // the host reads and clears the status, and the local side re-arms. A
  // repeated acknowledge leaves a request pending so that the clear promotes.
  task automatic status_exchange(input bit second);
    logic [15:0] cmd;
    cmd = 16'($urandom_range(16'h1000, 16'hFFFF));
    if (!second) begin
      send_access(OP_CMD, pick_word(), cmd);
      if ($urandom_range(0, 1)) send_access(OP_PARAM, pick_word(), pick_word());
      send_access(OP_LOGIC_RD, LR_FLAGS, pick_word());
      send_access(OP_RAM_RD, LW_CMD_LO, pick_word());
      send_access(OP_RAM_RD, LW_CMD_HI, pick_word());
      if ($urandom_range(0, 1)) send_access(OP_RAM_RD, 16'hCC6, pick_word());
      send_access(OP_RAM_WR, LW_STAT_LO, pick_word());
      send_access(OP_RAM_WR, LW_STAT_HI, pick_word());
      send_access(OP_LOGIC_WR, LR_ACK, pick_word());
      if ($urandom_range(0, 2) == 0) send_access(OP_LOGIC_WR, LR_ACK, pick_word());
      if ($urandom_range(0, 2) == 0) send_access(OP_PACK, pick_word(), pick_word());
      send_access(OP_GET_STAT, pick_word(), pick_word());
      send_access(OP_CLR_STAT, pick_word(), pick_word());
      if ($urandom_range(0, 1)) send_access(OP_GET_STAT, pick_word(), pick_word());
    end else begin
      send_access(OP_CMD2, pick_word(), cmd);
      if ($urandom_range(0, 1)) send_access(OP_PARAM2, pick_word(), pick_word());
      send_access(OP_LOGIC_RD, LR_FLAGS, pick_word());
      send_access(OP_RAM_RD, LW_CMD2_LO, pick_word());
      send_access(OP_RAM_RD, LW_CMD2_HI, pick_word());
      if ($urandom_range(0, 1)) send_access(OP_RAM_RD, 16'hB87, pick_word());
      send_access(OP_RAM_WR, LW_STAT2_LO, pick_word());
      send_access(OP_RAM_WR, LW_STAT2_HI, pick_word());
      send_access(OP_LOGIC_WR, LR_ACK2, pick_word());
      if ($urandom_range(0, 2) == 0) send_access(OP_LOGIC_WR, LR_ACK2, pick_word());
      if ($urandom_range(0, 2) == 0) send_access(OP_PACK2, pick_word(), pick_word());
      send_access(OP_GET_STAT2, pick_word(), pick_word());
      send_access(OP_CLR_STAT2, pick_word(), pick_word());
      if ($urandom_range(0, 1)) send_access(OP_GET_STAT2, pick_word(), pick_word());
    end
    send_access(OP_LOGIC_RD, LR_FLAGS, pick_word());
    send_access(OP_LOGIC_WR, LR_REARM, pick_word());
  endtask

  // Select a port, load some DMA parameters, and read them back, both through
  // the DMA path and now and then through the local window.
  task automatic dma_exchange();
    int n;
    send_access(OP_CMD, pick_word(), 16'($urandom_range(0, 16'h0FFF)));
    n = $urandom_range(1, 4);
    repeat (n) send_access(OP_DMA_WR, 16'($urandom_range(0, 3)), pick_word());
    if ($urandom_range(0, 3) == 0) send_access(OP_DMA_WR, pick_word(), pick_word());
    repeat (n) send_access(OP_DMA_RD, 16'($urandom_range(0, 3)), pick_word());
    if ($urandom_range(0, 3) == 0) send_access(OP_DMA_RD, pick_word(), pick_word());
    if ($urandom_range(0, 1)) send_access(OP_RAM_RD, pick_window_addr(), pick_word());
  endtask

  // An access of any kind with an address suited to its kind most of the time.
  task automatic loose_access();
    op_t         op;
    logic [15:0] addr;
    op = op_t'($urandom_range(0, 15));
    case (op)
      OP_RAM_RD, OP_RAM_WR:     addr = pick_window_addr();
      OP_LOGIC_RD, OP_LOGIC_WR: addr = pick_logic_addr();
      OP_DMA_WR, OP_DMA_RD:
        addr = ($urandom_range(0, 4) == 0) ? pick_word() : 16'($urandom_range(0, 3));
      default:                  addr = pick_word();
    endcase
    send_access(op, addr, pick_word());
  endtask

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Timed out after %0d cycles with %0d results outstanding.", LIMIT_CYCLES, pending);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A read of the command byte and of the status word before
    // anything was posted come first, then the fixed logic registers.
    send_access(OP_RAM_RD, LW_CMD_LO, 16'hFFFF);
    send_access(OP_GET_STAT, 16'hFFFF, 16'h0000);
    send_access(OP_LOGIC_RD, LR_ID, 16'h0000);
    send_access(OP_LOGIC_RD, LR_REV, 16'h0000);
    send_access(OP_LOGIC_RD, 16'hFFFF, 16'h0000);
    // Port select only (highest value below the command limit selects port 7),
    // then DMA parameters at both extremes of the select field and past it.
    send_access(OP_CMD, 16'h0000, 16'h0FFF);
    send_access(OP_DMA_WR, 16'h0000, 16'hFFFF);
    send_access(OP_DMA_WR, 16'h0003, 16'hA55A);
    send_access(OP_DMA_WR, 16'h0004, 16'h1234);
    send_access(OP_DMA_RD, 16'h0003, 16'h0000);
    send_access(OP_DMA_RD, 16'hFFFF, 16'h0000);
    // Real commands and parameters on both channels; each one raises a flag.
    send_access(OP_CMD, 16'h0000, 16'hFFFF);
    send_access(OP_CMD2, 16'hFFFF, 16'h0000);
    send_access(OP_PARAM, 16'h0000, 16'hABCD);
    send_access(OP_PARAM2, 16'h0000, 16'h1000);
    send_access(OP_PACK, 16'h0000, 16'h0000);
    send_access(OP_PACK2, 16'h0000, 16'h0000);
    // Command bytes mirrored into the window; shadow status fills from the
    // low byte of the data only; the second high byte also marks status valid.
    send_access(OP_RAM_RD, LW_CMD_HI, 16'h0000);
    send_access(OP_RAM_RD, LW_CMD2_LO, 16'h0000);
    send_access(OP_RAM_WR, LW_STAT_HI, 16'hFFA5);
    send_access(OP_RAM_WR, LW_STAT2_HI, 16'h003C);
    // First acknowledge promotes at once; the second leaves a request that
    // the clear then promotes. Reading the flags clears them before re-arm.
    send_access(OP_LOGIC_WR, LR_ACK, 16'h0000);
    send_access(OP_LOGIC_WR, LR_ACK, 16'h0000);
    send_access(OP_CLR_STAT, 16'h0000, 16'h0000);
    send_access(OP_LOGIC_RD, LR_FLAGS, 16'h0000);
    send_access(OP_LOGIC_WR, LR_REARM, 16'h0000);
    directed_beats = beats_sent;

    // Random part: mostly complete exchanges with random content, the rest
    // loose accesses that break up and interleave the exchanges.
    while (beats_sent < ACCESS_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: status_exchange($urandom_range(0, 1));
        4, 5:       dma_exchange();
        default:    repeat ($urandom_range(1, 4)) loose_access();
      endcase
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d accesses (%0d directed) and checked %0d result beats.",
             beats_sent, directed_beats, checked);
    $display("Covered host commands, status handshakes, DMA parameters and local window traffic.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
